// File: hdl/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg: shared types and constants of the conductivity meter chain
// Field widths, register indexes, arithmetic constants, front/back types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

   localparam int SMP_W      = 12;
   localparam int TEMP_W     = 15;
   localparam int RAW_W      = 22;
   localparam int OUT_W      = 24;
   localparam int SINE_W     = 11;
   localparam int TC_W       = 24;
   localparam int CELL_W     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_NUM_W  = 56;
   localparam int DIV_DEN_W  = 38;
   localparam int DEN_W      = 42;

   localparam logic [CSR_IDX_W-1:0] CSR_SINE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TC    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL2 = 3'd4;

   localparam logic [SMP_W-1:0]        SAMPLE_MAX  = 12'hfff;
   localparam logic [RAW_W-1:0]        RAW_ALL_ONE = 22'h3fffff;
   localparam logic [OUT_W-1:0]        OUT_MAX     = 24'hffffff;
   localparam logic [9:0]              SCALE_MILLI = 10'd1000;
   localparam logic [6:0]              HUNDREDTHS  = 7'd100;
   localparam logic signed [15:0]      REF_TEMP    = 16'sd2500;
   localparam logic signed [DEN_W-1:0] DEN_BASE    = 42'sd1677721600;

   localparam logic [SINE_W-1:0] RST_SINE = 11'd1024;
   localparam logic [TC_W-1:0]   RST_TC   = 24'd335544;
   localparam logic [CELL_W-1:0] RST_CELL = 20'd65536;

   typedef struct packed {
      logic [1:0]               channel;
      logic [SMP_W-1:0]         p2p;
      logic signed [TEMP_W-1:0] temperature;
   } wave_type;

   typedef struct packed {
      logic [SINE_W-1:0] sine;
      logic [TC_W-1:0]   tc;
      logic [CELL_W-1:0] cell0;
      logic [CELL_W-1:0] cell1;
      logic [CELL_W-1:0] cell2;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: hdl/cmc_ifs.sv
// ----------------------------------------------------------------------------
// cmc_ifs: channel interfaces of the conductivity meter chain
// Sample request, result response and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cmc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        channel;
   logic [11:0]       sample;
   logic              last_sample;
   logic signed [14:0] temperature;
   modport source(output valid, channel, sample, last_sample, temperature, input ready);
   modport sink(input valid, channel, sample, last_sample, temperature, output ready);
endinterface

interface cmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_channel;
   logic [11:0] peak_to_peak;
   logic [11:0] filtered_amplitude;
   logic [21:0] conductivity_raw;
   logic [23:0] conductivity_adjusted;
   logic [23:0] conductivity_compensated;
   logic        saturated;
   modport source(output valid, result_channel, peak_to_peak, filtered_amplitude,
                  conductivity_raw, conductivity_adjusted, conductivity_compensated,
                  saturated, input ready);
   modport sink(input valid, result_channel, peak_to_peak, filtered_amplitude,
                conductivity_raw, conductivity_adjusted, conductivity_compensated,
                saturated, output ready);
endinterface

interface cmc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/conductivity_meter_chain.sv
// ----------------------------------------------------------------------------
// conductivity_meter_chain: peak-to-peak conductivity meter
// Samples enter on req_ch, one per cycle, and are tracked for min/max. A
// sample with last_sample set closes the wave and queues it (queue of four).
// A sequencer then updates the channel moving average and computes raw,
// cell adjusted and temperature compensated conductivity; one result per
// wave leaves on rsp_ch. Registers are written on csr_ch (always ready).
// Each wave makes two passes through the shared 56-step divider, one for
// the raw and one for the compensated value; a zero sine amplitude or a
// non-positive denominator skips one pass, and a channel's first two waves
// also fill its taps first. Sample throughput is one per cycle until the
// wave queue holds four waves; the sequencer pops a new wave only after the
// last one's result is registered.
// Reset restores register defaults, restarts tracking and rearms priming.
// A stalled rsp_ch holds its result; the sequencer waits, the queue fills,
// and then req_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conductivity_meter_chain
   import cmc_pkg::*;
#(
   parameter int CHANNELS     = 3,
   parameter int FILTER_DEPTH = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   cmc_req_if.sink   req_ch,
   cmc_rsp_if.source rsp_ch,
   cmc_csr_if.sink   csr_ch
);

   cfg_type  cfg_ff;
   wave_type q_data;
   logic     q_valid, q_pop;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sine: RST_SINE, tc: RST_TC, cell0: RST_CELL, cell1: RST_CELL,
                     cell2: RST_CELL};
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SINE:  cfg_ff.sine  <= csr_ch.data[SINE_W-1:0];
            CSR_TC:    cfg_ff.tc    <= csr_ch.data[TC_W-1:0];
            CSR_CELL0: cfg_ff.cell0 <= csr_ch.data[CELL_W-1:0];
            CSR_CELL1: cfg_ff.cell1 <= csr_ch.data[CELL_W-1:0];
            CSR_CELL2: cfg_ff.cell2 <= csr_ch.data[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   cmc_front #(.CHANNELS(CHANNELS)) u_front (
      .clock(clock), .reset(reset), .req(req_ch),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
   );

   cmc_back #(.CHANNELS(CHANNELS), .FILTER_DEPTH(FILTER_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp_ch)
   );

endmodule

`default_nettype wire

// File: hdl/cmc_ram.sv
// ----------------------------------------------------------------------------
// cmc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 24,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/cmc_div.sv
// ----------------------------------------------------------------------------
// cmc_div: shared restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmc_div
   import cmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : shifted[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DIV_NUM_W - 1);
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

   a_no_start_busy : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start) else $error("divider started while busy");
   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a running division");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");

endmodule

`default_nettype wire

// File: hdl/cmc_front.sv
// ----------------------------------------------------------------------------
// cmc_front: wave tracker and wave queue
// Tracks min/max of the samples and queues one wave record per in-range last sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmc_front
   import cmc_pkg::*;
#(
   parameter int CHANNELS = 3
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cmc_req_if.sink    req,
   output wave_type   q_data,
   output logic       q_valid,
   input  wire logic  q_pop
);

   localparam int QDEPTH = 4;

   logic [SMP_W-1:0] max_ff, max_in;
   logic [SMP_W-1:0] min_ff, min_in;
   wave_type         mem_ff [QDEPTH];
   logic [1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [2:0]       cnt_ff, cnt_in;
   logic             transfer, in_range, push;

   assign req.ready = cnt_ff != 3'(QDEPTH);
   assign transfer  = req.valid && req.ready;
   assign in_range  = {1'b0, req.channel} < 3'(CHANNELS);

   always_comb begin
      max_in = (req.sample >= max_ff) ? req.sample : max_ff;
      min_in = (req.sample <= min_ff) ? req.sample : min_ff;
      push   = transfer && in_range && req.last_sample;
      cnt_in = cnt_ff + 3'(push) - 3'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= '0;
         min_ff    <= SAMPLE_MAX;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (transfer && in_range) begin
            if (req.last_sample) begin
               max_ff <= '0;
               min_ff <= SAMPLE_MAX;
            end else begin
               max_ff <= max_in;
               min_ff <= min_in;
            end
         end
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{channel: req.channel, p2p: max_in - min_in,
                                temperature: req.temperature};
      end
   end

   assign q_valid = cnt_ff != 3'd0;
   assign q_data  = mem_ff[rd_ptr_ff];

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDEPTH)) else $error("wave queue overflow");
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty wave queue");
   a_tracker_restart : assert property (@(posedge clock) disable iff (reset)
      push |=> max_ff == '0 && min_ff == SAMPLE_MAX) else $error("tracker not restarted");

endmodule

`default_nettype wire

// File: hdl/cmc_back.sv
// ----------------------------------------------------------------------------
// cmc_back: filter and conductivity sequencer
// Pops waves, updates the moving average and computes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmc_back
   import cmc_pkg::*;
#(
   parameter int CHANNELS     = 3,
   parameter int FILTER_DEPTH = 8
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire wave_type q_data,
   input  wire logic     q_valid,
   output logic          q_pop,
   cmc_rsp_if.source     rsp
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int SUM_W  = SMP_W + $clog2(FILTER_DEPTH);
   localparam int TAPS   = CHANNELS * FILTER_DEPTH;
   localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
   // average by reciprocal multiplication, exact for every sum below 2^SUM_W
   localparam int AVG_SH = SUM_W + POS_W;
   localparam int AVG_PW = SUM_W + AVG_SH + 1;
   localparam logic [AVG_SH:0] AVG_RECIP = (AVG_SH+1)'(((64'd1 << AVG_SH)
      + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_PRIME = 11'b00000000010,
      S_READ  = 11'b00000000100,
      S_UPD   = 11'b00000001000,
      S_DAVG  = 11'b00000010000,
      S_DRAW  = 11'b00000100000,
      S_MUL   = 11'b00001000000,
      S_ADJ   = 11'b00010000000,
      S_CHK   = 11'b00100000000,
      S_DCOMP = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type               st_ff, st_in;
   logic [CH_W-1:0]         ch_ff;
   logic [1:0]              chn_ff;
   logic [SMP_W-1:0]        p2p_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [POS_W-1:0]        cnt_ff;
   logic [SUM_W-1:0]        sum_ff   [CHANNELS];
   logic [POS_W-1:0]        pos_ff   [CHANNELS];
   logic [1:0]              prime_ff [CHANNELS];
   logic [SMP_W-1:0]        avg_ff;
   logic [RAW_W-1:0]        raw_ff;
   logic [RAW_W+CELL_W-1:0] prod_ff;
   logic signed [DEN_W-1:0] den_ff;
   logic [OUT_W-1:0]        adj_ff;
   logic [OUT_W-1:0]        comp_ff;
   logic                    sat_ff;

   logic                    out_valid_ff;
   logic [1:0]              out_ch_ff;
   logic [SMP_W-1:0]        out_p2p_ff, out_avg_ff;
   logic [RAW_W-1:0]        out_raw_ff;
   logic [OUT_W-1:0]        out_adj_ff, out_comp_ff;
   logic                    out_sat_ff;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr, base_addr;
   logic [SMP_W-1:0]        ram_rdata;
   logic [SUM_W-1:0]        sum_new;
   logic [AVG_PW-1:0]       avg_prod;
   logic [SMP_W-1:0]        avg_calc;
   logic [CELL_W-1:0]       cell_k;
   logic signed [15:0]      tdiff;
   logic signed [40:0]      tprod;
   logic [OUT_W-1:0]        comp_val;
   logic                    slot_free;
   div_req_type             dreq;
   div_rsp_type             drsp;

   cmc_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_taps (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(p2p_ff),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   cmc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign base_addr = AW'(32'(ch_ff) * 32'(FILTER_DEPTH));
   assign ram_raddr = base_addr + AW'(pos_ff[ch_ff]);
   assign sum_new   = sum_ff[ch_ff] - SUM_W'(ram_rdata) + SUM_W'(p2p_ff);
   assign avg_prod  = AVG_PW'(sum_new) * AVG_PW'(AVG_RECIP);
   assign avg_calc  = avg_prod[AVG_SH +: SMP_W];
   assign tdiff     = {temp_ff[TEMP_W-1], temp_ff} - REF_TEMP;
   assign tprod     = $signed({1'b0, cfg.tc}) * tdiff;
   assign slot_free = !out_valid_ff || rsp.ready;
   assign comp_val  = (|drsp.quo[DIV_NUM_W-1:OUT_W]) ? OUT_MAX : drsp.quo[OUT_W-1:0];

   always_comb begin
      case (chn_ff)
         2'd0:    cell_k = cfg.cell0;
         2'd1:    cell_k = cfg.cell1;
         default: cell_k = cfg.cell2;
      endcase
   end

   always_comb begin
      st_in     = st_ff;
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = base_addr + AW'(pos_ff[ch_ff]);
      dreq      = '{start: 1'b0, num: '0, den: '0};
      case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               st_in = (prime_ff[CH_W'(q_data.channel)] != 2'd0) ? S_PRIME : S_READ;
            end
         end
         S_PRIME: begin
            ram_we    = 1'b1;
            ram_waddr = base_addr + AW'(cnt_ff);
            if (cnt_ff == POS_W'(FILTER_DEPTH - 1)) begin
               st_in = S_READ;
            end
         end
         S_READ: st_in = S_UPD;
         S_UPD: begin
            ram_we = 1'b1;
            st_in  = S_DAVG;
         end
         S_DAVG: begin
            if (cfg.sine == '0) begin
               st_in = S_MUL;
            end else begin
               dreq  = '{start: 1'b1,
                         num: DIV_NUM_W'({10'd0, avg_ff} * 22'(SCALE_MILLI)),
                         den: DIV_DEN_W'(cfg.sine)};
               st_in = S_DRAW;
            end
         end
         S_DRAW: begin
            if (drsp.done) begin
               st_in = S_MUL;
            end
         end
         S_MUL: st_in = S_ADJ;
         S_ADJ: st_in = S_CHK;
         S_CHK: begin
            if (den_ff[DEN_W-1] || den_ff == '0) begin
               st_in = S_OUT;
            end else begin
               dreq  = '{start: 1'b1,
                         num: DIV_NUM_W'({31'(adj_ff * 31'(HUNDREDTHS)), 24'd0}),
                         den: den_ff[DIV_DEN_W-1:0]};
               st_in = S_DCOMP;
            end
         end
         S_DCOMP: begin
            if (drsp.done) begin
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i]   <= '0;
            prime_ff[i] <= 2'd2;
         end
      end else begin
         st_ff <= st_in;
         if (st_ff == S_OUT && slot_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (st_ff)
            S_PRIME: begin
               if (cnt_ff == POS_W'(FILTER_DEPTH - 1)) begin
                  prime_ff[ch_ff] <= prime_ff[ch_ff] - 2'd1;
               end
            end
            S_UPD: begin
               pos_ff[ch_ff] <= (pos_ff[ch_ff] == POS_W'(FILTER_DEPTH - 1)) ?
                                '0 : pos_ff[ch_ff] + POS_W'(1);
            end
            default: ;
         endcase
      end

      case (st_ff)
         S_IDLE: begin
            ch_ff   <= CH_W'(q_data.channel);
            chn_ff  <= q_data.channel;
            p2p_ff  <= q_data.p2p;
            temp_ff <= q_data.temperature;
            cnt_ff  <= '0;
            sat_ff  <= 1'b0;
         end
         S_PRIME: begin
            cnt_ff <= cnt_ff + POS_W'(1);
            if (cnt_ff == POS_W'(FILTER_DEPTH - 1)) begin
               sum_ff[ch_ff] <= SUM_W'(32'(p2p_ff) * 32'(FILTER_DEPTH));
            end
         end
         S_UPD: begin
            sum_ff[ch_ff] <= sum_new;
            avg_ff        <= avg_calc;
         end
         S_DAVG: begin
            if (cfg.sine == '0) begin
               raw_ff <= RAW_ALL_ONE;
               sat_ff <= 1'b1;
            end
         end
         S_DRAW: begin
            if (drsp.done) begin
               raw_ff <= drsp.quo[RAW_W-1:0];
            end
         end
         S_MUL: begin
            prod_ff <= (RAW_W+CELL_W)'(raw_ff) * (RAW_W+CELL_W)'(cell_k);
            den_ff  <= DEN_BASE + {tprod[40], tprod};
         end
         S_ADJ: begin
            if (|prod_ff[RAW_W+CELL_W-1:OUT_W+16]) begin
               adj_ff <= OUT_MAX;
               sat_ff <= 1'b1;
            end else begin
               adj_ff <= prod_ff[OUT_W+15:16];
            end
         end
         S_CHK: begin
            if (den_ff[DEN_W-1] || den_ff == '0) begin
               comp_ff <= OUT_MAX;
               sat_ff  <= 1'b1;
            end
         end
         S_DCOMP: begin
            if (drsp.done) begin
               comp_ff <= comp_val;
               if (|drsp.quo[DIV_NUM_W-1:OUT_W]) begin
                  sat_ff <= 1'b1;
               end
            end
         end
         S_OUT: begin
            if (slot_free) begin
               out_ch_ff   <= chn_ff;
               out_p2p_ff  <= p2p_ff;
               out_avg_ff  <= avg_ff;
               out_raw_ff  <= raw_ff;
               out_adj_ff  <= adj_ff;
               out_comp_ff <= comp_ff;
               out_sat_ff  <= sat_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid                    = out_valid_ff;
   assign rsp.result_channel           = out_ch_ff;
   assign rsp.peak_to_peak             = out_p2p_ff;
   assign rsp.filtered_amplitude       = out_avg_ff;
   assign rsp.conductivity_raw         = out_raw_ff;
   assign rsp.conductivity_adjusted    = out_adj_ff;
   assign rsp.conductivity_compensated = out_comp_ff;
   assign rsp.saturated                = out_sat_ff;

   a_upd_after_read : assert property (@(posedge clock) disable iff (reset)
      st_ff == S_UPD |-> $past(st_ff) == S_READ) else $error("tap update without read");
   a_pop_only_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == S_IDLE) else $error("wave popped while busy");
   a_out_from_seq : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(st_ff) == S_OUT) else $error("result without sequence");
   a_div_idle_wait : assert property (@(posedge clock) disable iff (reset)
      dreq.start |-> !drsp.busy) else $error("divider request while busy");

endmodule

`default_nettype wire
